// ===== rtl/core/syllable_spelling_check_top_assert.svh =====
// Assertion macros for the syllable spelling checker.
`ifndef SYLLABLE_SPELLING_CHECK_TOP_ASSERT_SVH
`define SYLLABLE_SPELLING_CHECK_TOP_ASSERT_SVH

// check a property on the rising clock edge, disabled in reset
`define SSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a property on the rising clock edge, live in reset too
`define SSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg
// Types, letter codes and group tables for the syllable spelling checker.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int unsigned CpW = 21;
  typedef logic [CpW-1:0] cp_t;
  typedef logic [7:0]     grp_set_t;

  localparam cp_t CP_DD = 21'h111;
  localparam cp_t CP_EC = 21'h0EA;
  localparam cp_t CP_AC = 21'h0E2;
  localparam cp_t CP_AB = 21'h103;
  localparam cp_t CP_OC = 21'h0F4;
  localparam cp_t CP_OH = 21'h1A1;
  localparam cp_t CP_UH = 21'h1B0;

  typedef struct packed {
    logic [2:0] grp;
    logic [1:0] len;
    cp_t        c0;
    cp_t        c1;
    cp_t        c2;
  } rom_entry_t;

  typedef struct packed {
    cp_t        c0;
    cp_t        c1;
    cp_t        c2;
    logic [2:0] len;
  } part_t;

  typedef struct packed {
    part_t    first;
    part_t    vowel;
    part_t    fin;
    logic     whole;
  } item_t;

  typedef struct packed {
    grp_set_t fs;
    grp_set_t vs;
    grp_set_t ls;
    logic     f_bad;
    logic     v_bad;
    logic     l_bad;
  } sets_t;

  function automatic rom_entry_t ent(input logic [2:0] g, input logic [1:0] l,
                                     input cp_t a, input cp_t b, input cp_t c);
    rom_entry_t e;
    e.grp = g; e.len = l; e.c0 = a; e.c1 = b; e.c2 = c;
    return e;
  endfunction

  localparam int unsigned NInit  = 33;
  localparam int unsigned NVowel = 59;
  localparam int unsigned NFinal = 10;

  function automatic cp_t ch(input byte b);
    return cp_t'(b);
  endfunction

  function automatic rom_entry_t init_rom(input int i);
    rom_entry_t e;
    case (i)
      0: e = ent(0,1,ch("b"),0,0);  1: e = ent(0,1,ch("d"),0,0);
      2: e = ent(0,1,CP_DD,0,0);    3: e = ent(0,1,ch("g"),0,0);
      4: e = ent(0,2,ch("g"),ch("h"),0); 5: e = ent(0,1,ch("m"),0,0);
      6: e = ent(0,1,ch("n"),0,0);  7: e = ent(0,2,ch("n"),ch("h"),0);
      8: e = ent(0,1,ch("p"),0,0);  9: e = ent(0,2,ch("p"),ch("h"),0);
      10: e = ent(0,1,ch("r"),0,0); 11: e = ent(0,1,ch("s"),0,0);
      12: e = ent(0,1,ch("t"),0,0); 13: e = ent(0,2,ch("t"),ch("r"),0);
      14: e = ent(0,1,ch("v"),0,0); 15: e = ent(0,1,ch("z"),0,0);
      16: e = ent(1,1,ch("c"),0,0); 17: e = ent(1,1,ch("h"),0,0);
      18: e = ent(1,1,ch("k"),0,0); 19: e = ent(1,2,ch("k"),ch("h"),0);
      20: e = ent(1,2,ch("k"),ch("r"),0); 21: e = ent(1,2,ch("q"),ch("u"),0);
      22: e = ent(1,2,ch("t"),ch("h"),0);
      23: e = ent(2,2,ch("c"),ch("h"),0); 24: e = ent(2,2,ch("g"),ch("i"),0);
      25: e = ent(2,1,ch("l"),0,0); 26: e = ent(2,2,ch("n"),ch("g"),0);
      27: e = ent(2,3,ch("n"),ch("g"),ch("h")); 28: e = ent(2,1,ch("x"),0,0);
      29: e = ent(3,1,ch("b"),0,0); 30: e = ent(3,1,CP_DD,0,0);
      31: e = ent(3,1,ch("l"),0,0);
      default: e = ent(4,1,ch("h"),0,0);
    endcase
    return e;
  endfunction

  function automatic rom_entry_t vowel_rom(input int i);
    rom_entry_t e;
    case (i)
      0: e = ent(0,1,CP_EC,0,0); 1: e = ent(0,1,ch("i"),0,0);
      2: e = ent(0,2,ch("u"),ch("a"),0); 3: e = ent(0,2,ch("u"),CP_EC,0);
      4: e = ent(0,2,ch("u"),ch("y"),0); 5: e = ent(0,1,ch("y"),0,0);
      6: e = ent(1,1,ch("a"),0,0); 7: e = ent(1,2,ch("i"),CP_EC,0);
      8: e = ent(1,2,ch("o"),ch("a"),0); 9: e = ent(1,3,ch("u"),ch("y"),CP_EC);
      10: e = ent(1,2,ch("y"),CP_EC,0);
      11: e = ent(2,1,CP_AC,0,0); 12: e = ent(2,1,CP_AB,0,0);
      13: e = ent(2,1,ch("e"),0,0); 14: e = ent(2,1,ch("o"),0,0);
      15: e = ent(2,2,ch("o"),ch("o"),0); 16: e = ent(2,1,CP_OC,0,0);
      17: e = ent(2,1,CP_OH,0,0); 18: e = ent(2,2,ch("o"),ch("e"),0);
      19: e = ent(2,1,ch("u"),0,0); 20: e = ent(2,1,CP_UH,0,0);
      21: e = ent(2,2,ch("u"),CP_AC,0); 22: e = ent(2,2,ch("u"),CP_OC,0);
      23: e = ent(2,2,CP_UH,CP_OH,0);
      24: e = ent(3,2,ch("o"),CP_AB,0);
      25: e = ent(4,2,ch("u"),CP_OH,0);
      26: e = ent(5,2,ch("a"),ch("i"),0); 27: e = ent(5,2,ch("a"),ch("o"),0);
      28: e = ent(5,2,ch("a"),ch("u"),0); 29: e = ent(5,2,CP_AC,ch("u"),0);
      30: e = ent(5,2,ch("a"),ch("y"),0); 31: e = ent(5,2,CP_AC,ch("y"),0);
      32: e = ent(5,2,ch("e"),ch("o"),0); 33: e = ent(5,2,CP_EC,ch("u"),0);
      34: e = ent(5,2,ch("i"),ch("a"),0); 35: e = ent(5,3,ch("i"),CP_EC,ch("u"));
      36: e = ent(5,2,ch("i"),ch("u"),0); 37: e = ent(5,3,ch("o"),ch("a"),ch("i"));
      38: e = ent(5,3,ch("o"),ch("a"),ch("o")); 39: e = ent(5,3,ch("o"),ch("a"),ch("y"));
      40: e = ent(5,3,ch("o"),ch("e"),ch("o")); 41: e = ent(5,2,ch("o"),ch("i"),0);
      42: e = ent(5,2,CP_OC,ch("i"),0); 43: e = ent(5,2,CP_OH,ch("i"),0);
      44: e = ent(5,2,CP_UH,ch("a"),0); 45: e = ent(5,3,ch("u"),CP_AC,ch("y"));
      46: e = ent(5,2,ch("u"),ch("i"),0); 47: e = ent(5,2,CP_UH,ch("i"),0);
      48: e = ent(5,3,ch("u"),CP_OC,ch("i")); 49: e = ent(5,3,CP_UH,CP_OH,ch("i"));
      50: e = ent(5,3,CP_UH,CP_OH,ch("u")); 51: e = ent(5,2,CP_UH,ch("u"),0);
      52: e = ent(5,3,ch("u"),ch("y"),ch("a")); 53: e = ent(5,3,ch("u"),ch("y"),ch("u"));
      54: e = ent(5,3,ch("u"),CP_EC,ch("u")); 55: e = ent(5,3,ch("y"),CP_EC,ch("u"));
      56: e = ent(6,1,CP_AB,0,0); 57: e = ent(6,1,ch("u"),0,0);
      default: e = ent(7,1,ch("i"),0,0);
    endcase
    return e;
  endfunction

  function automatic rom_entry_t final_rom(input int i);
    rom_entry_t e;
    case (i)
      0: e = ent(0,2,ch("c"),ch("h"),0); 1: e = ent(0,2,ch("n"),ch("h"),0);
      2: e = ent(1,1,ch("c"),0,0);       3: e = ent(1,2,ch("n"),ch("g"),0);
      4: e = ent(2,1,ch("m"),0,0);       5: e = ent(2,1,ch("n"),0,0);
      6: e = ent(2,1,ch("p"),0,0);       7: e = ent(2,1,ch("t"),0,0);
      8: e = ent(3,1,ch("k"),0,0);
      default: e = ent(4,1,ch("c"),0,0);
    endcase
    return e;
  endfunction

  function automatic cp_t base_letter(input cp_t c);
    cp_t r;
    case (c)
      CP_AC, CP_AB: r = ch("a");
      CP_EC:        r = ch("e");
      CP_OC, CP_OH: r = ch("o");
      CP_UH:        r = ch("u");
      CP_DD:        r = ch("d");
      default:      r = c;
    endcase
    return r;
  endfunction

  function automatic logic ch_eq(input cp_t ic, input cp_t rc, input logic loose);
    return (ic == rc) || (loose && (base_letter(rc) == ic));
  endfunction

  function automatic logic ent_match(input rom_entry_t e, input part_t p,
                                     input logic whole, input logic loose);
    logic [2:0] el;
    logic       ok;
    el = {1'b0, e.len};
    ok = !(el < p.len) && !(whole && (el > p.len));
    if (p.len > 3'd0 && !ch_eq(p.c0, e.c0, loose)) ok = 1'b0;
    if (p.len > 3'd1 && !ch_eq(p.c1, e.c1, loose)) ok = 1'b0;
    if (p.len > 3'd2 && !ch_eq(p.c2, e.c2, loose)) ok = 1'b0;
    return ok;
  endfunction

  localparam logic [7:0] CvRom [5] = '{8'h27, 8'h3F, 8'h2F, 8'h40, 8'h80};
  localparam logic [7:0] VcRom [8] = '{8'h05, 8'h07, 8'h06, 8'h06,
                                       8'h00, 8'h00, 8'h08, 8'h10};

endpackage

// ===== rtl/core/ssc_stream_if.sv =====
// ----------------------------------------------------------------------------
// ssc_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface ssc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ssc_match.sv =====
// ----------------------------------------------------------------------------
// ssc_match
// Matches the three parts of one syllable against the group tables.
// ----------------------------------------------------------------------------
module ssc_match
  import ssc_pkg::*;
(
  input  item_t item,
  output sets_t sets
);
  logic f_whole, v_whole, l_whole;
  grp_set_t fs, vs, ls;
  part_t fin;
  rom_entry_t e;

  // final length is two bits wide
  assign fin = {item.fin.c0, item.fin.c1, item.fin.c2, 1'b0, item.fin.len[1:0]};

  assign f_whole = item.whole || (item.vowel.len != 3'd0);
  assign v_whole = item.whole || (fin.len != 3'd0);
  assign l_whole = item.whole;

  always_comb begin
    fs = '0;
    vs = '0;
    ls = '0;
    e  = '0;
    for (int i = 0; i < NInit; i++) begin
      e = init_rom(i);
      if (ent_match(e, item.first, f_whole, 1'b0)) fs[e.grp] = 1'b1;
    end
    for (int i = 0; i < NVowel; i++) begin
      e = vowel_rom(i);
      if (ent_match(e, item.vowel, v_whole, !item.whole)) vs[e.grp] = 1'b1;
    end
    for (int i = 0; i < NFinal; i++) begin
      e = final_rom(i);
      if (ent_match(e, fin, l_whole, 1'b0)) ls[e.grp] = 1'b1;
    end
  end

  assign sets.fs    = (item.first.len != 3'd0) ? fs : '0;
  assign sets.vs    = (item.vowel.len != 3'd0) ? vs : '0;
  assign sets.ls    = (fin.len != 3'd0) ? ls : '0;
  assign sets.f_bad = (item.first.len != 3'd0) && (fs == '0);
  assign sets.v_bad = (item.vowel.len != 3'd0) && (vs == '0);
  assign sets.l_bad = (fin.len != 3'd0) && (ls == '0);
endmodule

// ===== rtl/core/ssc_cross.sv =====
// ----------------------------------------------------------------------------
// ssc_cross
// Cross-checks the group sets through the pairing tables.
// ----------------------------------------------------------------------------
module ssc_cross
  import ssc_pkg::*;
(
  input  sets_t sets,
  output logic  ok
);
  logic [7:0] cv_allow, vc_allow;
  logic       cv;

  always_comb begin
    cv_allow = '0;
    vc_allow = '0;
    for (int i = 0; i < 5; i++) if (sets.fs[i]) cv_allow = cv_allow | CvRom[i];
    for (int i = 0; i < 8; i++) if (sets.vs[i]) vc_allow = vc_allow | VcRom[i];
    cv = (cv_allow & sets.vs) != '0;
    if (sets.f_bad || sets.v_bad || sets.l_bad) ok = 1'b0;
    else if (sets.vs == '0) ok = sets.fs != '0;
    else if (sets.fs != '0 && (!cv || sets.ls == '0)) ok = cv;
    else if (sets.ls != '0) ok = (vc_allow & sets.ls) != '0;
    else ok = 1'b1;
  end
endmodule

// ===== rtl/core/syllable_spelling_check_top.sv =====
// ----------------------------------------------------------------------------
// syllable_spelling_check_top
// Checks initial, vowel and final parts of a syllable against the spelling
// tables; one verdict beat per input beat.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  in_ch     in   item_t (three parts with lengths, whole flag)
//  out_ch    out  valid_res
//
//  One beat a cycle unless out_ch stalls. Input register, table match,
//  cross-check, result register. Stalls on out_ch back up through the two
//  registers; a stage takes a new beat when it is empty or the one ahead of
//  it moves on. Reset empties both stages.
module syllable_spelling_check_top
  import ssc_pkg::*;
(
  input logic         clk,
  input logic         rst,
  ssc_stream_if.sink   in_ch,
  ssc_stream_if.source out_ch
);
`include "syllable_spelling_check_top_assert.svh"

  item_t item;
  logic  item_vld;
  logic  res;
  logic  res_vld;
  sets_t sets;
  logic  ok;
  logic  res_take, item_take;

  assign res_take  = !res_vld || out_ch.ready;
  assign item_take = !item_vld || res_take;
  assign in_ch.ready = item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
      res_vld  <= 1'b0;
    end else begin
      if (item_take) item_vld <= in_ch.valid;
      if (res_take)  res_vld  <= item_vld;
    end
    if (item_take && in_ch.valid) item <= in_ch.data;
    if (res_take && item_vld)     res  <= ok;
  end

  ssc_match u_match (.item(item), .sets(sets));
  ssc_cross u_cross (.sets(sets), .ok(ok));

  assign out_ch.valid = res_vld;
  assign out_ch.data  = res;

  `SSC_ASSERT(a_hold, res_vld && !out_ch.ready |=> res_vld && $stable(res), "result dropped")
  `SSC_ASSERT(a_flow, in_ch.valid && in_ch.ready |=> item_vld, "beat lost in input stage")
  `SSC_ASSERT_ALWAYS(a_rst, rst |=> !res_vld && !item_vld, "reset left beats")
endmodule

// ===== verif/tb_syllable_spelling_check_top.sv =====
// ----------------------------------------------------------------------------
// tb_syllable_spelling_check_top
// Drives syllable parts into the spelling checker and compares each verdict
// beat with an in-bench prediction built from its own spelling tables.
// ----------------------------------------------------------------------------
module tb_syllable_spelling_check_top;
  import ssc_pkg::*;

  typedef struct {
    int  grp;
    int  len;
    cp_t c [3];
  } spell_ent_t;

  localparam int unsigned IdleLimit = 2000;

  logic clk;
  logic rst;
  logic quiet;
  int   errors;
  int   idle_cycles;
  logic verdicts_due [$];
  spell_ent_t tbls [3][$];

  ssc_stream_if #(.payload_t(item_t)) in_ch ();
  ssc_stream_if #(.payload_t(logic))  out_ch ();

  syllable_spelling_check_top u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ascii capitals stand for the marked letters
  function automatic cp_t letter(input byte b);
    cp_t r;
    case (b)
      "D": r = CP_DD;
      "E": r = CP_EC;
      "A": r = CP_AC;
      "B": r = CP_AB;
      "O": r = CP_OC;
      "H": r = CP_OH;
      "U": r = CP_UH;
      default: r = cp_t'(b);
    endcase
    return r;
  endfunction

  function automatic cp_t unmarked(input cp_t c);
    cp_t r;
    r = c;
    if (c == CP_AC || c == CP_AB) r = cp_t'("a");
    if (c == CP_EC) r = cp_t'("e");
    if (c == CP_OC || c == CP_OH) r = cp_t'("o");
    if (c == CP_UH) r = cp_t'("u");
    if (c == CP_DD) r = cp_t'("d");
    return r;
  endfunction

  task automatic load_tbl(input int k, input string s []);
    spell_ent_t e;
    foreach (s[i]) begin
      e.grp = s[i][0] - "0";
      e.len = s[i].len() - 1;
      for (int j = 0; j < 3; j++)
        e.c[j] = (j < e.len) ? letter(s[i][j+1]) : '0;
      tbls[k] = {tbls[k], e};
    end
  endtask

  function automatic logic [7:0] group_set(input int k, input cp_t c [3], input int len,
                                           input logic whole, input logic complete);
    logic [7:0] set;
    logic       ok;
    set = '0;
    for (int i = 0; i < tbls[k].size(); i++) begin
      if (tbls[k][i].len < len || (whole && tbls[k][i].len > len)) continue;
      ok = 1'b1;
      for (int j = 0; j < len; j++)
        if (c[j] != tbls[k][i].c[j] && !(!complete && unmarked(tbls[k][i].c[j]) == c[j]))
          ok = 1'b0;
      if (ok) set[tbls[k][i].grp] = 1'b1;
    end
    return set;
  endfunction

  function automatic logic spelling_ok(input item_t it);
    logic [7:0] cv [5];
    logic [7:0] vc [8];
    logic [7:0] fs, vs, ls, allowed;
    cp_t        c [3];
    int         flen, vlen, llen;
    cv = '{8'h27, 8'h3F, 8'h2F, 8'h40, 8'h80};
    vc = '{8'h05, 8'h07, 8'h06, 8'h06, 8'h00, 8'h00, 8'h08, 8'h10};
    flen = int'(it.first.len);
    vlen = int'(it.vowel.len);
    llen = int'(it.fin.len[1:0]);
    fs = '0; vs = '0; ls = '0;
    if (flen != 0) begin
      c = '{it.first.c0, it.first.c1, it.first.c2};
      fs = group_set(0, c, flen, it.whole || vlen != 0, 1'b1);
      if (fs == 0) return 1'b0;
    end
    if (vlen != 0) begin
      c = '{it.vowel.c0, it.vowel.c1, it.vowel.c2};
      vs = group_set(1, c, vlen, it.whole || llen != 0, it.whole);
      if (vs == 0) return 1'b0;
    end
    if (llen != 0) begin
      c = '{it.fin.c0, it.fin.c1, '0};
      ls = group_set(2, c, llen, it.whole, 1'b1);
      if (ls == 0) return 1'b0;
    end
    if (vs == 0) return fs != 0;
    if (fs != 0) begin
      allowed = '0;
      for (int i = 0; i < 5; i++) if (fs[i]) allowed |= cv[i];
      if ((allowed & vs) == 0) return 1'b0;
      if (ls == 0) return 1'b1;
    end
    if (ls != 0) begin
      allowed = '0;
      for (int i = 0; i < 8; i++) if (vs[i]) allowed |= vc[i];
      return (allowed & ls) != 0;
    end
    return 1'b1;
  endfunction

  task automatic report(input string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic send_syllable(input item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = int'($urandom_range(1, 6));
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    verdicts_due = {verdicts_due, spelling_ok(it)};
  endtask

  function automatic cp_t rand_cp();
    string marks;
    marks = "DEAOBHU";
    case ($urandom_range(0, 3))
      0: return cp_t'($urandom_range(0, 21'h1FFFFF));
      1: return cp_t'($urandom_range(0, 1114111));
      2: return cp_t'($urandom_range("a", "z"));
      default: return letter(marks[$urandom_range(0, 6)]);
    endcase
  endfunction

  function automatic part_t rand_part(input int maxlen);
    part_t p;
    p.c0 = rand_cp(); p.c1 = rand_cp(); p.c2 = rand_cp();
    p.len = 3'($urandom_range(0, maxlen));
    return p;
  endfunction

  function automatic part_t word_part(input int k, input int maxlen);
    part_t      p;
    spell_ent_t e;
    cp_t        c [3];
    p = rand_part(maxlen);
    if ($urandom_range(0, 4) == 0) begin
      p.len = 0;
      return p;
    end
    e = tbls[k][$urandom_range(0, tbls[k].size() - 1)];
    c = e.c;
    p.len = 3'(($urandom_range(0, 2) == 0) ? $urandom_range(1, e.len) : e.len);
    for (int j = 0; j < 3; j++) begin
      if (j >= p.len) c[j] = rand_cp();
      else if ($urandom_range(0, 5) == 0) c[j] = unmarked(c[j]);
      else if ($urandom_range(0, 15) == 0) c[j] = rand_cp();
    end
    p.c0 = c[0]; p.c1 = c[1]; p.c2 = c[2];
    if ($urandom_range(0, 20) == 0) p.len = 3'($urandom_range(0, maxlen));
    return p;
  endfunction

  function automatic item_t word_item();
    item_t it;
    it.first = word_part(0, 7);
    it.vowel = word_part(1, 7);
    it.fin   = word_part(2, 3);
    it.whole = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic part_t str_part(input string s);
    part_t p;
    p = '0;
    p.len = 3'(s.len());
    if (s.len() > 0) p.c0 = letter(s[0]);
    if (s.len() > 1) p.c1 = letter(s[1]);
    if (s.len() > 2) p.c2 = letter(s[2]);
    return p;
  endfunction

  function automatic item_t syl(input string f, input string v, input string l,
                                input logic whole);
    item_t it;
    it.first = str_part(f);
    it.vowel = str_part(v);
    it.fin   = str_part(l);
    it.whole = whole;
    return it;
  endfunction

  task automatic test_directed();
    item_t it;
    send_syllable(syl("", "", "", 1'b0));
    send_syllable(syl("b", "a", "", 1'b1));
    send_syllable(syl("ngh", "E", "", 1'b1));
    send_syllable(syl("ng", "", "", 1'b0));
    send_syllable(syl("ng", "", "", 1'b1));
    send_syllable(syl("qu", "a", "ng", 1'b1));
    send_syllable(syl("th", "UH", "ng", 1'b1));
    send_syllable(syl("th", "uo", "ng", 1'b0));
    send_syllable(syl("D", "a", "", 1'b0));
    send_syllable(syl("d", "a", "", 1'b0));
    send_syllable(syl("", "a", "", 1'b0));
    send_syllable(syl("", "a", "", 1'b1));
    send_syllable(syl("k", "i", "", 1'b1));
    send_syllable(syl("k", "a", "", 1'b1));
    send_syllable(syl("t", "", "ng", 1'b0));
    send_syllable(syl("", "", "ng", 1'b0));
    send_syllable(syl("", "uy", "E", 1'b0));
    send_syllable(syl("gh", "i", "", 1'b1));
    it = syl("ngh", "uyE", "ch", 1'b1);
    it.first.len = 3'd4;
    send_syllable(it);
    it.first.len = 3'd7; it.vowel.len = 3'd7; it.fin.len = 3'd3;
    send_syllable(it);
    it = syl("b", "a", "", 1'b0);
    it.vowel.c0 = '1; it.first.c1 = '1; it.first.c2 = '1;
    send_syllable(it);
    send_syllable('1);
    send_syllable(syl("h", "i", "", 1'b0));
    send_syllable(syl("l", "o", "c", 1'b1));
  endtask

  task automatic test_words(input int n);
    repeat (n) send_syllable(word_item());
  endtask

  task automatic test_noise(input int n);
    item_t it;
    repeat (n) begin
      it.first = rand_part(7);
      it.vowel = rand_part(7);
      it.fin   = rand_part(3);
      it.whole = 1'($urandom_range(0, 1));
      send_syllable(it);
    end
  endtask

  task automatic test_steady(input int n);
    quiet = 1'b1;
    test_words(n);
  endtask

  // result side
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (verdicts_due.size() == 0) begin
        report("verdict beat with none expected");
      end else if (out_ch.data !== verdicts_due[0]) begin
        report($sformatf("valid_res %b, expected %b", out_ch.data, verdicts_due[0]));
        void'(verdicts_due.pop_front());
      end else begin
        void'(verdicts_due.pop_front());
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    quiet        = 1'b0;
    errors       = 0;
    idle_cycles  = 0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    load_tbl(0, {"0b","0d","0D","0g","0gh","0m","0n","0nh","0p","0ph","0r","0s","0t",
                 "0tr","0v","0z","1c","1h","1k","1kh","1kr","1qu","1th","2ch","2gi",
                 "2l","2ng","2ngh","2x","3b","3D","3l","4h"});
    load_tbl(1, {"0E","0i","0ua","0uE","0uy","0y","1a","1iE","1oa","1uyE","1yE","2A",
                 "2B","2e","2o","2oo","2O","2H","2oe","2u","2U","2uA","2uO","2UH",
                 "3oB","4uH","5ai","5ao","5au","5Au","5ay","5Ay","5eo","5Eu","5ia",
                 "5iEu","5iu","5oai","5oao","5oay","5oeo","5oi","5Oi","5Hi","5Ua",
                 "5uAy","5ui","5Ui","5uOi","5UHi","5UHu","5Uu","5uya","5uyu","5uEu",
                 "5yEu","6B","6u","7i"});
    load_tbl(2, {"0ch","0nh","1c","1ng","2m","2n","2p","2t","3k","4c"});
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_words(400);
    test_noise(100);
    test_steady(100);
    in_ch.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
